/* hw/rtl/pthc_pkg.sv */
// Shared types and constants for the pressure, temperature and humidity compensation unit.
package pthc_pkg;

  // Configuration port geometry and register indexes.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_CALIB    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_CALIB_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_CALIB_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESS_CALIB_C = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HUM_CALIB     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HAS_HUMIDITY  = 3'd5;

  // Pressure divider: 64-bit dividend magnitude, 31-bit divisor magnitude.
  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 31;

  // Humidity clamp limit before the final shift.
  localparam logic signed [32:0] HUM_LIMIT = 33'sd419430400;

  typedef struct packed {
    logic [19:0] adc_pressure;
    logic [19:0] adc_temperature;
    logic [15:0] adc_humidity;
  } pthc_in_t;

  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
    logic               pressure_valid;
    logic [16:0]        humidity_q22_10;
  } pthc_out_t;

  // Results that ride along with the pressure division.
  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] hv;
  } pthc_side_t;

  typedef struct packed {
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
    logic                 q_neg;
    logic                 den_zero;
    pthc_side_t           side;
  } pthc_div_t;

  typedef struct packed {
    logic [DIV_NUM_W-1:0] quo;
    logic                 den_zero;
    pthc_side_t           side;
  } pthc_divo_t;

endpackage

/* hw/rtl/pthc_div.sv */
// Pipelined restoring divider for the pressure quotient, one quotient bit per stage.
module pthc_div import pthc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  logic       in_valid,
  input  pthc_div_t  in_d,
  output logic       out_valid,
  output pthc_divo_t out_d
);

  localparam int Steps = DIV_NUM_W;

  logic [Steps-1:0]     vld_r;
  logic [DIV_NUM_W-1:0] nq_r   [Steps];
  logic [DIV_DEN_W-1:0] rem_r  [Steps];
  logic [DIV_DEN_W-1:0] den_r  [Steps];
  logic                 neg_r  [Steps];
  logic                 zero_r [Steps];
  pthc_side_t           side_r [Steps];

  logic [DIV_NUM_W-1:0] nq_nxt  [Steps];
  logic [DIV_DEN_W-1:0] rem_nxt [Steps];

  // One shift, compare and subtract step per stage.
  always_comb begin
    logic [DIV_NUM_W-1:0] src_nq;
    logic [DIV_DEN_W-1:0] src_rem;
    logic [DIV_DEN_W-1:0] src_den;
    logic [DIV_DEN_W:0]   trial;
    for (int k = 0; k < Steps; k++) begin
      if (k == 0) begin
        src_nq  = in_d.num;
        src_rem = '0;
        src_den = in_d.den;
      end else begin
        src_nq  = nq_r[k-1];
        src_rem = rem_r[k-1];
        src_den = den_r[k-1];
      end
      trial = {src_rem, src_nq[DIV_NUM_W-1]};
      if (trial >= {1'b0, src_den}) begin
        rem_nxt[k] = DIV_DEN_W'(trial - {1'b0, src_den});
        nq_nxt[k]  = {src_nq[DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt[k] = trial[DIV_DEN_W-1:0];
        nq_nxt[k]  = {src_nq[DIV_NUM_W-2:0], 1'b0};
      end
    end
  end

  // Valid bits travel with the stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[Steps-2:0], in_valid};
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < Steps; k++) begin
        nq_r[k]  <= nq_nxt[k];
        rem_r[k] <= rem_nxt[k];
        if (k == 0) begin
          den_r[k]  <= in_d.den;
          neg_r[k]  <= in_d.q_neg;
          zero_r[k] <= in_d.den_zero;
          side_r[k] <= in_d.side;
        end else begin
          den_r[k]  <= den_r[k-1];
          neg_r[k]  <= neg_r[k-1];
          zero_r[k] <= zero_r[k-1];
          side_r[k] <= side_r[k-1];
        end
      end
    end
  end

  // Apply the quotient sign after the last step.
  assign out_valid      = vld_r[Steps-1];
  assign out_d.quo      = neg_r[Steps-1] ? (DIV_NUM_W'(0) - nq_r[Steps-1]) : nq_r[Steps-1];
  assign out_d.den_zero = zero_r[Steps-1];
  assign out_d.side     = side_r[Steps-1];

endmodule

/* hw/rtl/pth_sensor_compensation_unit.sv */
// Pipeline: 9 front stages, 64 divider stages and 4 back stages; the 64-bit pressure
// division, one quotient bit per stage, sets the depth.
// Throughput: one beat per cycle; a stalled result freezes the whole pipeline in place.
// Reset: synchronous active-low rst_n clears all valid bits and all calibration registers.
// Top level of the pressure, temperature and humidity compensation unit.
module pth_sensor_compensation_unit import pthc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  pthc_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output pthc_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Calibration registers.
  logic [47:0] temp_calib_r;
  logic [63:0] press_a_r;
  logic [63:0] press_b_r;
  logic [15:0] press_c_r;
  logic [63:0] hum_calib_r;
  logic        has_hum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_calib_r <= '0;
      press_a_r    <= '0;
      press_b_r    <= '0;
      press_c_r    <= '0;
      hum_calib_r  <= '0;
      has_hum_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TEMP_CALIB:    temp_calib_r <= cfg_wdata[47:0];
        CFG_PRESS_CALIB_A: press_a_r    <= cfg_wdata;
        CFG_PRESS_CALIB_B: press_b_r    <= cfg_wdata;
        CFG_PRESS_CALIB_C: press_c_r    <= cfg_wdata[15:0];
        CFG_HUM_CALIB:     hum_calib_r  <= cfg_wdata;
        CFG_HAS_HUMIDITY:  has_hum_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Coefficient fields.
  logic        [15:0] t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9, h2;
  logic        [7:0]  h1, h3;
  logic signed [11:0] h4, h5;
  logic signed [7:0]  h6;

  assign t1 = temp_calib_r[15:0];
  assign t2 = temp_calib_r[31:16];
  assign t3 = temp_calib_r[47:32];
  assign p1 = press_a_r[15:0];
  assign p2 = press_a_r[31:16];
  assign p3 = press_a_r[47:32];
  assign p4 = press_a_r[63:48];
  assign p5 = press_b_r[15:0];
  assign p6 = press_b_r[31:16];
  assign p7 = press_b_r[47:32];
  assign p8 = press_b_r[63:48];
  assign p9 = press_c_r;
  assign h1 = hum_calib_r[7:0];
  assign h2 = hum_calib_r[23:8];
  assign h3 = hum_calib_r[31:24];
  assign h4 = hum_calib_r[43:32];
  assign h5 = hum_calib_r[55:44];
  assign h6 = hum_calib_r[63:56];

  // The whole pipeline moves unless the result register holds an untaken beat.
  logic adv;
  logic p4_v_r;
  assign adv      = !p4_v_r || out_ready;
  assign in_ready = adv;

  // Valid bits of the front and back stages.
  logic [8:0] fv_r;
  logic       div_ov;
  logic [2:0] bv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r   <= '0;
      bv_r   <= '0;
      p4_v_r <= 1'b0;
    end else if (adv) begin
      fv_r   <= {fv_r[7:0], in_valid};
      bv_r   <= {bv_r[1:0], div_ov};
      p4_v_r <= bv_r[2];
    end
  end

  // Stage 1: temperature differences and first products.
  logic signed [17:0] d1;
  logic signed [16:0] d2;
  logic signed [33:0] s1_pa_r, s1_dd_r;
  logic        [19:0] s1_ap_r;
  logic        [15:0] s1_ah_r;

  assign d1 = $signed({1'b0, in_data.adc_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
  assign d2 = $signed({1'b0, in_data.adc_temperature[19:4]}) - $signed({1'b0, t1});

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_pa_r <= d1 * t2;
      s1_dd_r <= d2 * d2;
      s1_ap_r <= in_data.adc_pressure;
      s1_ah_r <= in_data.adc_humidity;
    end
  end

  // Stage 2: scale the linear term, multiply the square term by T3.
  logic signed [22:0] s2_a_r;
  logic signed [37:0] s2_pb_r;
  logic        [19:0] s2_ap_r;
  logic        [15:0] s2_ah_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_a_r  <= s1_pa_r[33:11];
      s2_pb_r <= $signed({1'b0, s1_dd_r[32:12]}) * t3;
      s2_ap_r <= s1_ap_r;
      s2_ah_r <= s1_ah_r;
    end
  end

  // Stage 3: fine temperature.
  logic signed [24:0] s3_tf_r;
  logic        [19:0] s3_ap_r;
  logic        [15:0] s3_ah_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_tf_r <= 25'(s2_a_r) + 25'($signed(s2_pb_r[37:14]));
      s3_ap_r <= s2_ap_r;
      s3_ah_r <= s2_ah_r;
    end
  end

  // Stage 4: temperature result and the offsets for pressure and humidity.
  logic signed [27:0] t5;
  logic signed [25:0] s4_v1_r, s4_x_r;
  logic        [31:0] s4_temp_r;
  logic        [19:0] s4_ap_r;
  logic        [15:0] s4_ah_r;

  assign t5 = (28'(s3_tf_r) <<< 2) + 28'(s3_tf_r) + 28'sd128;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_v1_r   <= 26'(s3_tf_r) - 26'sd128000;
      s4_x_r    <= 26'(s3_tf_r) - 26'sd76800;
      s4_temp_r <= 32'($signed(t5[27:8]));
      s4_ap_r   <= s3_ap_r;
      s4_ah_r   <= s3_ah_r;
    end
  end

  // Stage 5: square of the pressure offset and first-order products of both offsets.
  logic signed [51:0] s5_vv_r;
  logic signed [41:0] s5_v1p5_r, s5_v1p2_r;
  logic signed [37:0] s5_h5x_r;
  logic signed [33:0] s5_xh6_r;
  logic signed [34:0] s5_xh3_r;
  logic        [31:0] s5_temp_r;
  logic        [19:0] s5_ap_r;
  logic        [15:0] s5_ah_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_vv_r   <= s4_v1_r * s4_v1_r;
      s5_v1p5_r <= s4_v1_r * p5;
      s5_v1p2_r <= s4_v1_r * p2;
      s5_h5x_r  <= h5 * s4_x_r;
      s5_xh6_r  <= s4_x_r * h6;
      s5_xh3_r  <= s4_x_r * $signed({1'b0, h3});
      s5_temp_r <= s4_temp_r;
      s5_ap_r   <= s4_ap_r;
      s5_ah_r   <= s4_ah_r;
    end
  end

  // Stage 6: square terms, first humidity factor and the humidity cross product.
  logic signed [39:0] f1w;
  logic signed [63:0] s6_vvp6_r, s6_vvp3_r;
  logic signed [41:0] s6_v1p5_r, s6_v1p2_r;
  logic        [31:0] s6_f1_r;
  logic signed [48:0] s6_gm_r;
  logic        [31:0] s6_temp_r;
  logic        [19:0] s6_ap_r;

  assign f1w = $signed({10'b0, s5_ah_r, 14'b0}) - (40'(h4) <<< 20) - 40'(s5_h5x_r)
             + 40'sd16384;

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_vvp6_r <= s5_vv_r * p6;
      s6_vvp3_r <= s5_vv_r * p3;
      s6_v1p5_r <= s5_v1p5_r;
      s6_v1p2_r <= s5_v1p2_r;
      s6_f1_r   <= 32'($signed(f1w[39:15]));
      s6_gm_r   <= $signed(s5_xh6_r[33:10])
                 * (25'($signed(s5_xh3_r[34:11])) + 25'sd32768);
      s6_temp_r <= s5_temp_r;
      s6_ap_r   <= s5_ap_r;
    end
  end

  // Stage 7: pressure sums and the H2 product.
  logic signed [63:0] s7_v2_r, s7_v1b_r;
  logic signed [55:0] s7_f2p_r;
  logic        [31:0] s7_f1_r, s7_temp_r;
  logic        [19:0] s7_ap_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_v2_r   <= s6_vvp6_r + (64'(s6_v1p5_r) <<< 17) + (64'(p4) <<< 35);
      s7_v1b_r  <= (s6_vvp3_r >>> 8) + (64'(s6_v1p2_r) <<< 12);
      s7_f2p_r  <= (40'($signed(s6_gm_r[48:10])) + 40'sd2097152) * h2;
      s7_f1_r   <= s6_f1_r;
      s7_temp_r <= s6_temp_r;
      s7_ap_r   <= s6_ap_r;
    end
  end

  // Stage 8: divisor product, dividend and second humidity factor.
  logic [63:0] pm_base;
  logic [20:0] pdiff;
  logic [63:0] numw;
  logic [63:0] s8_pm_r, s8_num_r;
  logic [31:0] s8_f1_r, s8_f2_r, s8_temp_r;

  assign pm_base = 64'(s7_v1b_r) + 64'h0000_8000_0000_0000;
  assign pdiff   = 21'h10_0000 - 21'(s7_ap_r);
  assign numw    = {12'b0, pdiff, 31'b0} - 64'(s7_v2_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      s8_pm_r   <= pm_base * 64'(p1);
      s8_num_r  <= numw * 64'd3125;
      s8_f2_r   <= 32'((s7_f2p_r + 56'sd8192) >>> 14);
      s8_f1_r   <= s7_f1_r;
      s8_temp_r <= s7_temp_r;
    end
  end

  // Stage 9: operand magnitudes for the divider, humidity product wrapped to 32 bits.
  logic [DIV_DEN_W-1:0] den;
  pthc_div_t            s9_r;

  assign den = s8_pm_r[63:33];

  always_ff @(posedge clk) begin
    if (adv) begin
      s9_r.num       <= s8_num_r[63] ? (64'd0 - s8_num_r) : s8_num_r;
      s9_r.den       <= den[DIV_DEN_W-1] ? (DIV_DEN_W'(0) - den) : den;
      s9_r.q_neg     <= s8_num_r[63] ^ den[DIV_DEN_W-1];
      s9_r.den_zero  <= (den == '0);
      s9_r.side.temp <= s8_temp_r;
      s9_r.side.hv   <= 32'(s8_f1_r * s8_f2_r);
    end
  end

  // Pressure division.
  pthc_divo_t div_o;

  pthc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (fv_r[8]),
    .in_d     (s9_r),
    .out_valid(div_ov),
    .out_d    (div_o)
  );

  // Back stage 1: P9 and P8 products, humidity square.
  logic signed [50:0] q13;
  logic signed [16:0] hs17;
  logic signed [63:0] b1_a1_r, b1_w2p_r, b1_q_r;
  logic        [63:0] b1_q13_r;
  logic signed [33:0] b1_ss_r;
  logic        [31:0] b1_hv_r, b1_temp_r;
  logic               b1_zero_r;

  assign q13  = div_o.quo[63:13];
  assign hs17 = div_o.side.hv[31:15];

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_a1_r   <= p9 * q13;
      b1_w2p_r  <= p8 * $signed(div_o.quo);
      b1_q_r    <= div_o.quo;
      b1_q13_r  <= 64'(q13);
      b1_ss_r   <= hs17 * hs17;
      b1_hv_r   <= div_o.side.hv;
      b1_temp_r <= div_o.side.temp;
      b1_zero_r <= div_o.den_zero;
    end
  end

  // Back stage 2: partial products of the 64-bit square term, H1 product.
  logic        [63:0] b2_ll_r;
  logic        [31:0] b2_lh_r, b2_hl_r;
  logic        [34:0] b2_hs_r;
  logic signed [63:0] b2_w2p_r, b2_q_r;
  logic        [31:0] b2_hv_r, b2_temp_r;
  logic               b2_zero_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      b2_ll_r   <= b1_a1_r[31:0] * b1_q13_r[31:0];
      b2_lh_r   <= b1_a1_r[31:0] * b1_q13_r[63:32];
      b2_hl_r   <= b1_a1_r[63:32] * b1_q13_r[31:0];
      b2_hs_r   <= b1_ss_r[33:7] * h1;
      b2_w2p_r  <= b1_w2p_r;
      b2_q_r    <= b1_q_r;
      b2_hv_r   <= b1_hv_r;
      b2_temp_r <= b1_temp_r;
      b2_zero_r <= b1_zero_r;
    end
  end

  // Back stage 3: pressure correction sum and humidity difference.
  logic        [63:0] w1m;
  logic signed [63:0] w1;
  logic signed [63:0] b3_sum_r;
  logic signed [32:0] b3_hd_r;
  logic        [31:0] b3_temp_r;
  logic               b3_zero_r;

  assign w1m = b2_ll_r + {32'(b2_lh_r + b2_hl_r), 32'b0};
  assign w1  = $signed(w1m) >>> 25;

  always_ff @(posedge clk) begin
    if (adv) begin
      b3_sum_r  <= b2_q_r + w1 + (b2_w2p_r >>> 19);
      b3_hd_r   <= 33'($signed(b2_hv_r)) - $signed({2'b0, b2_hs_r[34:4]});
      b3_temp_r <= b2_temp_r;
      b3_zero_r <= b2_zero_r;
    end
  end

  // Result register: final pressure scaling, humidity clamp and zero-divisor flag.
  logic signed [63:0] pfin;
  logic signed [32:0] hclamp;
  pthc_out_t          out_r;

  assign pfin = (b3_sum_r >>> 8) + (64'(p7) <<< 4);

  always_comb begin
    if (b3_hd_r < 0) begin
      hclamp = '0;
    end else if (b3_hd_r > HUM_LIMIT) begin
      hclamp = HUM_LIMIT;
    end else begin
      hclamp = b3_hd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.temperature_centi <= b3_temp_r;
      out_r.pressure_q24_8    <= b3_zero_r ? 32'd0 : pfin[31:0];
      out_r.pressure_valid    <= !b3_zero_r;
      out_r.humidity_q22_10   <= has_hum_r ? hclamp[28:12] : 17'd0;
    end
  end

  assign out_valid = p4_v_r;
  assign out_data  = out_r;

  // A result beat flagged invalid carries zero pressure.
  a_press_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.pressure_valid |-> out_data.pressure_q24_8 == 32'd0)
    else $error("pressure not zero with divisor zero");

  // Humidity stays within the clamp range.
  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.humidity_q22_10 <= 17'd102400)
    else $error("humidity above clamp limit");

  // Without a humidity channel the humidity field reads zero.
  a_no_hum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !has_hum_r |-> out_data.humidity_q22_10 == 17'd0)
    else $error("humidity nonzero without humidity channel");

  // An empty result register never blocks the input.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

endmodule
